// File: rtl/ssht_pkg.sv
// Shared widths, constants and stage payload types of the segment-sphere hit test.
package ssht_pkg;

    localparam int CW    = 32;
    localparam int DW    = 16;
    localparam int LW    = 31;
    localparam int DPW   = DW + LW;
    localparam int WW    = CW + 1;
    localparam int L2W   = 2 * LW;
    localparam int DOTW  = 82;
    localparam int REMW  = 80;
    localparam int QW    = 16;
    localparam int TW    = QW + 1;
    localparam int PW    = 35;
    localparam int SQW   = 70;
    localparam int DISTW = SQW + 2;

    localparam logic [TW-1:0] T_ONE = TW'(1) << QW;

    typedef struct packed {
        logic [2:0][DPW-1:0] d;
        logic [2:0][WW-1:0]  w;
        logic [L2W-1:0]      r2;
    } geo_t;

    typedef struct packed {
        logic reject;
        logic one;
        logic pos;
    } cls_t;

endpackage

// File: rtl/ssht_front.sv
// Front pipeline: segment vector, centre offset, dot product and range classification.
module ssht_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [ssht_pkg::CW-1:0] start_x,
    input  logic signed [ssht_pkg::CW-1:0] start_y,
    input  logic signed [ssht_pkg::CW-1:0] start_z,
    input  logic signed [ssht_pkg::DW-1:0] dir_x,
    input  logic signed [ssht_pkg::DW-1:0] dir_y,
    input  logic signed [ssht_pkg::DW-1:0] dir_z,
    input  logic        [ssht_pkg::LW-1:0] seg_length,
    input  logic signed [ssht_pkg::CW-1:0] centre_x,
    input  logic signed [ssht_pkg::CW-1:0] centre_y,
    input  logic signed [ssht_pkg::CW-1:0] centre_z,
    input  logic        [ssht_pkg::LW-1:0] sphere_radius,
    output logic                          valid,
    output ssht_pkg::geo_t                geo,
    output logic [ssht_pkg::L2W-1:0]      l2,
    output logic [ssht_pkg::REMW-1:0]     rem,
    output ssht_pkg::cls_t                cls
);

    logic [4:0] vld_reg;
    ssht_pkg::geo_t geo_reg [5];
    ssht_pkg::geo_t geo1_next;
    logic [ssht_pkg::L2W-1:0] l2_reg [5];
    logic [ssht_pkg::L2W-1:0] l2_next;

    logic signed [ssht_pkg::DW-1:0]  dirv [3];
    logic signed [ssht_pkg::CW-1:0]  stv [3];
    logic signed [ssht_pkg::CW-1:0]  cenv [3];
    logic signed [ssht_pkg::LW:0]    len_s;
    logic signed [ssht_pkg::DPW-1:0] dprod [3];
    logic signed [ssht_pkg::WW-1:0]  wdiff [3];

    logic signed [57:0] pl_reg [3];
    logic signed [57:0] pl_next [3];
    logic signed [55:0] ph_reg [3];
    logic signed [55:0] ph_next [3];
    logic signed [79:0] term_reg [3];
    logic signed [79:0] term_next [3];
    logic signed [ssht_pkg::DOTW-1:0] dot_reg;
    logic signed [ssht_pkg::DOTW-1:0] dot_next;

    logic signed [77:0] r2s;
    logic signed [77:0] l2s;
    logic signed [77:0] lim;
    logic signed [77:0] negr;
    ssht_pkg::cls_t cls_reg;
    ssht_pkg::cls_t cls_next;
    logic [ssht_pkg::REMW-1:0] rem_reg;
    logic [ssht_pkg::REMW-1:0] rem_next;

    assign dirv  = '{dir_x, dir_y, dir_z};
    assign stv   = '{start_x, start_y, start_z};
    assign cenv  = '{centre_x, centre_y, centre_z};
    assign len_s = $signed({1'b0, seg_length});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dprod[i] = dirv[i] * len_s;
            wdiff[i] = cenv[i] - stv[i];
            geo1_next.d[i] = dprod[i];
            geo1_next.w[i] = wdiff[i];
        end
        geo1_next.r2 = sphere_radius * sphere_radius;
        l2_next = seg_length * seg_length;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pl_next[i] = $signed({1'b0, geo_reg[0].d[i][23:0]}) * $signed(geo_reg[0].w[i]);
            ph_next[i] = $signed(geo_reg[0].d[i][ssht_pkg::DPW-1:24]) * $signed(geo_reg[0].w[i]);
            term_next[i] = $signed({ph_reg[i], 24'b0}) + pl_reg[i];
        end
        dot_next = term_reg[0] + term_reg[1] + term_reg[2];
    end

    always_comb
    begin
        r2s  = $signed({2'b0, geo_reg[3].r2, 14'b0});
        l2s  = $signed({2'b0, l2_reg[3], 14'b0});
        lim  = r2s + l2s;
        negr = -r2s;
        cls_next.reject = (dot_reg < negr) || (dot_reg > lim);
        cls_next.one    = dot_reg >= l2s;
        cls_next.pos    = dot_reg > 0;
        if (cls_next.pos && !cls_next.one)
        begin
            rem_next = {dot_reg[77:0], 2'b00};
        end
        else
        begin
            rem_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= geo1_next;
            l2_reg[0]  <= l2_next;
            for (int k = 1; k < 5; k++)
            begin
                geo_reg[k] <= geo_reg[k-1];
                l2_reg[k]  <= l2_reg[k-1];
            end
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            term_reg <= term_next;
            dot_reg  <= dot_next;
            cls_reg  <= cls_next;
            rem_reg  <= rem_next;
        end
    end

    assign valid = vld_reg[4];
    assign geo   = geo_reg[4];
    assign l2    = l2_reg[4];
    assign rem   = rem_reg;
    assign cls   = cls_reg;

endmodule

// File: rtl/ssht_div_stage.sv
// One restoring division step that settles one bit of the projection parameter.
module ssht_div_stage
#(
    parameter int BIT = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      up_valid,
    input  logic [ssht_pkg::REMW-1:0] up_rem,
    input  logic [ssht_pkg::QW-1:0]   up_quot,
    input  logic [ssht_pkg::L2W-1:0]  up_l2,
    input  ssht_pkg::cls_t            up_cls,
    input  ssht_pkg::geo_t            up_geo,
    output logic                      valid,
    output logic [ssht_pkg::REMW-1:0] rem,
    output logic [ssht_pkg::QW-1:0]   quot,
    output logic [ssht_pkg::L2W-1:0]  l2,
    output ssht_pkg::cls_t            cls,
    output ssht_pkg::geo_t            geo
);

    logic valid_reg;
    logic [ssht_pkg::REMW-1:0] rem_reg;
    logic [ssht_pkg::REMW-1:0] rem_next;
    logic [ssht_pkg::QW-1:0] quot_reg;
    logic [ssht_pkg::QW-1:0] quot_next;
    logic [ssht_pkg::L2W-1:0] l2_reg;
    ssht_pkg::cls_t cls_reg;
    ssht_pkg::geo_t geo_reg;
    logic [ssht_pkg::REMW-1:0] cand;

    always_comb
    begin
        cand = {{(ssht_pkg::REMW - ssht_pkg::L2W){1'b0}}, up_l2} << BIT;
        if (up_rem >= cand)
        begin
            rem_next  = up_rem - cand;
            quot_next = up_quot | (ssht_pkg::QW'(1) << BIT);
        end
        else
        begin
            rem_next  = up_rem;
            quot_next = up_quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            l2_reg   <= up_l2;
            cls_reg  <= up_cls;
            geo_reg  <= up_geo;
        end
    end

    assign valid = valid_reg;
    assign rem   = rem_reg;
    assign quot  = quot_reg;
    assign l2    = l2_reg;
    assign cls   = cls_reg;
    assign geo   = geo_reg;

endmodule

// File: rtl/ssht_dist.sv
// Back pipeline: closest point, squared distance and the hit decision.
module ssht_dist
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    up_valid,
    input  logic [ssht_pkg::QW-1:0] up_quot,
    input  ssht_pkg::cls_t          up_cls,
    input  ssht_pkg::geo_t          up_geo,
    output logic                    valid,
    output logic                    hit,
    output logic [ssht_pkg::TW-1:0] hit_param
);

    logic [5:0] vld_reg;
    ssht_pkg::geo_t geo_reg [5];
    logic [ssht_pkg::TW-1:0] t_reg [5];
    logic rej_reg [5];
    logic [ssht_pkg::TW-1:0] t_next;

    logic [40:0] tl_reg [3];
    logic [40:0] tl_next [3];
    logic signed [40:0] th_reg [3];
    logic signed [40:0] th_next [3];
    logic signed [64:0] v [3];
    logic signed [64:0] vr [3];
    logic signed [ssht_pkg::PW-1:0] p_reg [3];
    logic signed [ssht_pkg::PW-1:0] p_next [3];
    logic signed [ssht_pkg::PW:0] e [3];
    logic signed [ssht_pkg::PW:0] mag [3];
    logic [ssht_pkg::PW-1:0] ae_reg [3];
    logic [ssht_pkg::PW-1:0] ae_next [3];
    logic [35:0] ll_reg [3];
    logic [35:0] ll_next [3];
    logic [34:0] hl_reg [3];
    logic [34:0] hl_next [3];
    logic [33:0] hh_reg [3];
    logic [33:0] hh_next [3];
    logic [ssht_pkg::SQW-1:0] sq_reg [3];
    logic [ssht_pkg::SQW-1:0] sq_next [3];
    logic [ssht_pkg::DISTW-1:0] dist_sum;
    logic hit_reg;
    logic hit_next;
    logic [ssht_pkg::TW-1:0] param_reg;
    logic [ssht_pkg::TW-1:0] param_next;

    always_comb
    begin
        if (up_cls.one)
        begin
            t_next = ssht_pkg::T_ONE;
        end
        else if (up_cls.pos)
        begin
            t_next = {1'b0, up_quot};
        end
        else
        begin
            t_next = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            tl_next[i] = t_next * up_geo.d[i][23:0];
            th_next[i] = $signed({1'b0, t_next}) * $signed(up_geo.d[i][ssht_pkg::DPW-1:24]);
            v[i]  = $signed({th_reg[i], 24'b0}) + $signed({1'b0, tl_reg[i]});
            vr[i] = v[i] + 65'sh2000_0000;
            p_next[i] = vr[i][64:30];
            e[i]   = p_reg[i] - $signed(geo_reg[1].w[i]);
            mag[i] = (e[i] < 0) ? -e[i] : e[i];
            ae_next[i] = mag[i][ssht_pkg::PW-1:0];
            ll_next[i] = ae_reg[i][17:0] * ae_reg[i][17:0];
            hl_next[i] = ae_reg[i][34:18] * ae_reg[i][17:0];
            hh_next[i] = ae_reg[i][34:18] * ae_reg[i][34:18];
            sq_next[i] = {hh_reg[i], 36'b0} + {hl_reg[i], 19'b0} + ll_reg[i];
        end
        dist_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];
        hit_next = !rej_reg[4] && (dist_sum <= {{(ssht_pkg::DISTW - ssht_pkg::L2W){1'b0}},
                                                geo_reg[4].r2});
        param_next = hit_next ? t_reg[4] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], up_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= up_geo;
            t_reg[0]   <= t_next;
            rej_reg[0] <= up_cls.reject;
            for (int k = 1; k < 5; k++)
            begin
                geo_reg[k] <= geo_reg[k-1];
                t_reg[k]   <= t_reg[k-1];
                rej_reg[k] <= rej_reg[k-1];
            end
            tl_reg    <= tl_next;
            th_reg    <= th_next;
            p_reg     <= p_next;
            ae_reg    <= ae_next;
            ll_reg    <= ll_next;
            hl_reg    <= hl_next;
            hh_reg    <= hh_next;
            sq_reg    <= sq_next;
            hit_reg   <= hit_next;
            param_reg <= param_next;
        end
    end

    assign valid     = vld_reg[5];
    assign hit       = hit_reg;
    assign hit_param = param_reg;

endmodule

// File: rtl/segment_sphere_hit_test_unit.sv
// Top level of the segment-sphere hit test pipeline.
// The unit takes one beat per cycle while not frozen and returns one result beat
// for each, in order: five front stages form the dot product, sixteen
// divider stages settle the projection parameter one bit each, and six back
// stages build the closest point and its squared distance. A stalled result
// freezes the whole pipeline, so the input stalls only while a finished beat
// waits at the output.
module segment_sphere_hit_test_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [ssht_pkg::CW-1:0] start_x,
    input  logic signed [ssht_pkg::CW-1:0] start_y,
    input  logic signed [ssht_pkg::CW-1:0] start_z,
    input  logic signed [ssht_pkg::DW-1:0] dir_x,
    input  logic signed [ssht_pkg::DW-1:0] dir_y,
    input  logic signed [ssht_pkg::DW-1:0] dir_z,
    input  logic        [ssht_pkg::LW-1:0] seg_length,
    input  logic signed [ssht_pkg::CW-1:0] centre_x,
    input  logic signed [ssht_pkg::CW-1:0] centre_y,
    input  logic signed [ssht_pkg::CW-1:0] centre_z,
    input  logic        [ssht_pkg::LW-1:0] sphere_radius,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [ssht_pkg::TW-1:0]       hit_param
);

    logic en;
    logic dv [17];
    logic [ssht_pkg::REMW-1:0] drem [17];
    logic [ssht_pkg::QW-1:0] dquot [17];
    logic [ssht_pkg::L2W-1:0] dl2 [17];
    ssht_pkg::cls_t dcls [17];
    ssht_pkg::geo_t dgeo [17];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;
    assign dquot[0] = '0;

    ssht_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .start_x       (start_x),
        .start_y       (start_y),
        .start_z       (start_z),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .seg_length    (seg_length),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .centre_z      (centre_z),
        .sphere_radius (sphere_radius),
        .valid         (dv[0]),
        .geo           (dgeo[0]),
        .l2            (dl2[0]),
        .rem           (drem[0]),
        .cls           (dcls[0])
    );

    for (genvar k = 0; k < 16; k++)
    begin : g_div
        ssht_div_stage #(.BIT(15 - k)) u_stage
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (dv[k]),
            .up_rem   (drem[k]),
            .up_quot  (dquot[k]),
            .up_l2    (dl2[k]),
            .up_cls   (dcls[k]),
            .up_geo   (dgeo[k]),
            .valid    (dv[k+1]),
            .rem      (drem[k+1]),
            .quot     (dquot[k+1]),
            .l2       (dl2[k+1]),
            .cls      (dcls[k+1]),
            .geo      (dgeo[k+1])
        );
    end

    ssht_dist u_dist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .up_valid  (dv[16]),
        .up_quot   (dquot[16]),
        .up_cls    (dcls[16]),
        .up_geo    (dgeo[16]),
        .valid     (out_valid),
        .hit       (hit),
        .hit_param (hit_param)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_param == '0)
        else $error("miss beat carries a nonzero parameter");

    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> hit_param <= ssht_pkg::T_ONE)
        else $error("hit parameter above one");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while the pipeline is frozen");

endmodule

// File: dv/tb_segment_sphere_hit_test_unit.sv
// Self-checking testbench for the segment-sphere hit test unit.
`timescale 1ns / 1ps

module tb_segment_sphere_hit_test_unit;

    import ssht_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1600;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] start[3];
        logic signed [DW-1:0] dir[3];
        logic [LW-1:0]        len;
        logic signed [CW-1:0] centre[3];
        logic [LW-1:0]        rad;
    } seg_item_t;

    typedef struct {
        logic          hit;
        logic [TW-1:0] param;
    } hit_result_t;

    class hit_scoreboard;
        hit_result_t expected_q[$];
        int          errors;

        function hit_result_t predict_hit(seg_item_t it);
            wide_t s[3], u[3], c[3], d[3], w[3];
            wide_t len, rad, dot, l2, r2, l2s, r2s, dist_sq, t, p, e;
            hit_result_t r;
            len = it.len;
            rad = it.rad;
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                s[i] = it.start[i];
                u[i] = it.dir[i];
                c[i] = it.centre[i];
                d[i] = u[i] * len;
                w[i] = c[i] - s[i];
                dot  = dot + d[i] * w[i];
            end
            l2  = len * len;
            r2  = rad * rad;
            l2s = l2 <<< 14;
            r2s = r2 <<< 14;
            r.hit   = 1'b0;
            r.param = '0;
            if (dot < -r2s || dot > r2s + l2s)
                return r;
            if (dot >= l2s)
                t = wide_t'(T_ONE);
            else if (dot > 0)
                t = (dot <<< 2) / l2;
            else
                t = 0;
            dist_sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                p       = (t * d[i] + (wide_t'(1) <<< 29)) >>> 30;
                e       = p - w[i];
                dist_sq = dist_sq + e * e;
            end
            if (dist_sq <= r2)
            begin
                r.hit   = 1'b1;
                r.param = t[TW-1:0];
            end
            return r;
        endfunction

        function void note_item(seg_item_t it);
            expected_q.push_back(predict_hit(it));
        endfunction

        function void check_result(logic h, logic [TW-1:0] p);
            hit_result_t x;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result beat hit=%0b hit_param=%0d", $time, h, p);
                errors++;
                return;
            end
            x = expected_q.pop_front();
            if (h !== x.hit)
            begin
                $display("%0t: hit expected %0b actual %0b", $time, x.hit, h);
                errors++;
            end
            if (p !== x.param)
            begin
                $display("%0t: hit_param expected %0d actual %0d", $time, x.param, p);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CW-1:0] start_x, start_y, start_z;
    logic signed [DW-1:0] dir_x, dir_y, dir_z;
    logic [LW-1:0]        seg_length;
    logic signed [CW-1:0] centre_x, centre_y, centre_z;
    logic [LW-1:0]        sphere_radius;
    logic                 out_valid;
    logic                 out_stall;
    logic                 hit;
    logic [TW-1:0]        hit_param;

    hit_scoreboard sb;
    int            cycles = 0;
    bit            sender_done;

    segment_sphere_hit_test_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_x       (start_x),
        .start_y       (start_y),
        .start_z       (start_z),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .seg_length    (seg_length),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .centre_z      (centre_z),
        .sphere_radius (sphere_radius),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .hit_param     (hit_param)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        seg_item_t it;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_segment_sphere_hit_test_unit failed");
            $finish;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            it.start  = '{start_x, start_y, start_z};
            it.dir    = '{dir_x, dir_y, dir_z};
            it.len    = seg_length;
            it.centre = '{centre_x, centre_y, centre_z};
            it.rad    = sphere_radius;
            sb.note_item(it);
        end
        if (rst_n && out_valid && !out_stall)
            sb.check_result(hit, hit_param);
    end

    function automatic seg_item_t make_item(int sx, int sy, int sz, int ux, int uy, int uz,
                                            int unsigned l, int cx, int cy, int cz,
                                            int unsigned r);
        seg_item_t it;
        it.start  = '{sx, sy, sz};
        it.dir    = '{DW'(ux), DW'(uy), DW'(uz)};
        it.len    = LW'(l);
        it.centre = '{cx, cy, cz};
        it.rad    = LW'(r);
        return it;
    endfunction

    function automatic int rand_dir();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic seg_item_t random_item();
        seg_item_t it;
        int        span;
        if ($urandom_range(0, 7) == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                it.start[i]  = $urandom;
                it.centre[i] = $urandom;
                it.dir[i]    = DW'(rand_dir());
            end
            it.len = LW'($urandom);
            it.rad = LW'($urandom);
            return it;
        end
        span = 1 << $urandom_range(8, 24);
        for (int i = 0; i < 3; i++)
        begin
            it.start[i]  = $urandom_range(0, 2 * (1 << 24)) - (1 << 24);
            it.dir[i]    = DW'(rand_dir());
            it.centre[i] = it.start[i] + $urandom_range(0, 2 * span) - span;
        end
        it.len = LW'($urandom_range(0, 2 * span));
        it.rad = LW'($urandom_range(0, 2 * span));
        return it;
    endfunction

    task automatic send_item(seg_item_t it, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_x       <= it.start[0];
        start_y       <= it.start[1];
        start_z       <= it.start[2];
        dir_x         <= it.dir[0];
        dir_y         <= it.dir[1];
        dir_z         <= it.dir[2];
        seg_length    <= it.len;
        centre_x      <= it.centre[0];
        centre_y      <= it.centre[1];
        centre_z      <= it.centre[2];
        sphere_radius <= it.rad;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    initial
    begin
        int beats;
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        beats = 0;
        forever
        begin
            if (beats == 300)
                n = 250;
            else if ((beats / 200) % 3 == 1)
                n = 0;
            else
                n = $urandom_range(0, 13);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            beats++;
        end
    end

    initial
    begin
        seg_item_t directed_q[$];
        bit        calm;
        sb            = new();
        sender_done   = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        start_x       = '0;
        start_y       = '0;
        start_z       = '0;
        dir_x         = '0;
        dir_y         = '0;
        dir_z         = '0;
        seg_length    = '0;
        centre_x      = '0;
        centre_y      = '0;
        centre_z      = '0;
        sphere_radius = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_q.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_item(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                                       -16384, -16384, -16384, 32'h7fffffff,
                                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        directed_q.push_back(make_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                       16384, 16384, 16384, 32'h7fffffff,
                                       -32'sh80000000, -32'sh80000000, -32'sh80000000, 0));
        directed_q.push_back(make_item(0, 0, 0, 16384, 0, 0, 65536, 131072, 0, 0, 65536));
        directed_q.push_back(make_item(0, 0, 0, 16384, 0, 0, 65536, 131073, 0, 0, 65536));
        directed_q.push_back(make_item(0, 0, 0, 16384, 0, 0, 65536, -65536, 0, 0, 65536));
        directed_q.push_back(make_item(0, 0, 0, 16384, 0, 0, 0, 0, 65536, 0, 65536));
        directed_q.push_back(make_item(5, 6, 7, 16384, 0, 0, 0, 5, 6, 7, 0));
        directed_q.push_back(make_item(0, 0, 0, 16384, 0, 0, 262144, 100000, 30000, 0, 40000));
        directed_q.push_back(make_item(0, 0, 0, 16384, 16384, 0, 65536, 40000, 40000, 0, 20000));
        directed_q.push_back(make_item(0, 0, 0, 0, -16384, 0, 262144, 0, -131072, 10, 65536));
        directed_q.push_back(make_item(0, 0, 0, 0, 0, 16384, 196608, 0, 0, 400000, 1000));
        directed_q.push_back(make_item(1000, -1000, 0, 11585, 11585, 0, 200000,
                                       90000, 88000, 500, 5000));
        directed_q.push_back(make_item(0, 0, 0, 16384, 0, 0, 65536, 32768, 0, 0, 0));
        directed_q.push_back(make_item(0, 0, 0, 0, 0, 0, 65536, 1, 1, 1, 2));
        foreach (directed_q[i])
            send_item(directed_q[i], draw_gap(i % 3 == 0));
        drain();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 800)
                drain();
            calm = (k >= 280 && k < 420) || (k >= 1000 && k < 1150);
            send_item(random_item(), draw_gap(calm));
        end
        in_valid    <= 1'b0;
        sender_done = 1'b1;
    end

    initial
    begin
        wait (sender_done);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_segment_sphere_hit_test_unit passed");
        else
            $display("tb_segment_sphere_hit_test_unit failed");
        $finish;
    end

endmodule
